// ===== rtl/soa_pkg.sv =====
// Package for the slab object allocator: item types and status codes.
package soa_pkg;

  localparam int unsigned OBJ_SIZE_W = 13;
  localparam int unsigned FIELD_ADDR_W = 32;
  localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RESET = 13'd64;
  localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_MIN = 13'd8;

  typedef enum logic [2:0] {
    ST_ALLOC = 3'd0,
    ST_FREED = 3'd1,
    ST_FAIL  = 3'd2,
    ST_NULL  = 3'd3,
    ST_FULL  = 3'd4
  } alloc_status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic                    mode;
    logic [FIELD_ADDR_W-1:0] object_addr;
    logic [FIELD_ADDR_W-1:0] page_addr;
    logic                    page_ok;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_ADDR_W-1:0] result_addr;
    logic [2:0]              status;
    logic                    new_page_taken;
  } out_item_t;

endpackage

// ===== rtl/slab_object_allocator.sv =====
// Slab object allocator: free-address stack in a memory, lazy page carving.
//
// Requests arrive on the in_ channel (valid/ready) and each gives exactly one
// result item on the out_ channel (valid/ready), in request order. A free
// pushes a non-zero address onto the stack held in a single-port-per-side
// memory. An allocate pops the most recent free address, or else carves the
// next object from the current page, or else takes the offered page.
// Frees, carve steps, page takes and failures are decided at acceptance and
// their result is visible in the next cycle. A pop reads the stack memory,
// whose read data is registered, so its result passes through the read
// register and the S_POP state into the output register. One request is in
// flight at a time: a new request is taken once the previous result has been
// loaded into the output register and that register is empty or being taken
// in the same cycle. When the receiver stalls, the result is held in the
// output register and no further request is taken. Reset clears the stack
// count, the carving state and the object size (to 64); stack memory
// contents need no clearing, as only entries below the count are ever read.
module slab_object_allocator #(
  parameter int unsigned PAGE_BYTES  = 4096,
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  soa_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output soa_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [soa_pkg::OBJ_SIZE_W-1:0]      cfg_wdata
);

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(STACK_DEPTH);
  localparam int unsigned LEFT_W = $clog2(PAGE_BYTES + 1);
  localparam int unsigned CMP_W  =
    (LEFT_W > soa_pkg::OBJ_SIZE_W) ? LEFT_W : soa_pkg::OBJ_SIZE_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [ADDR_BITS-1:0]           carve_next_r, carve_next_nxt;
  logic [LEFT_W-1:0]              carve_left_r, carve_left_nxt;
  logic [soa_pkg::OBJ_SIZE_W-1:0] obj_size_r;
  logic                           out_valid_r, out_valid_nxt;
  soa_pkg::out_item_t             out_item_r, out_item_nxt;

  logic [ADDR_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [ADDR_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [ADDR_BITS-1:0] mem_wdata;

  logic                           accept;
  logic [soa_pkg::OBJ_SIZE_W-1:0] eff_size;
  logic [ADDR_BITS-1:0]           obj_a, page_a;
  logic [CMP_W-1:0]               size_c, left_c;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign eff_size = (obj_size_r < soa_pkg::OBJ_SIZE_MIN) ? soa_pkg::OBJ_SIZE_MIN
                                                         : obj_size_r;
  assign obj_a  = ADDR_BITS'(in_item.object_addr);
  assign page_a = ADDR_BITS'(in_item.page_addr);
  assign size_c = CMP_W'(eff_size);
  assign left_c = CMP_W'(carve_left_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    carve_next_nxt = carve_next_r;
    carve_left_nxt = carve_left_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = count_r[IDX_W-1:0];
    mem_wdata      = obj_a;
    mem_raddr      = IDX_W'(count_r - CNT_W'(1));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.result_addr    = '0;
          out_item_nxt.new_page_taken = 1'b0;
          out_valid_nxt               = 1'b1;
          if (in_item.mode == soa_pkg::MODE_FREE) begin
            if (obj_a == '0) begin
              out_item_nxt.status = soa_pkg::ST_NULL;
            end else if (count_r >= CNT_W'(STACK_DEPTH)) begin
              out_item_nxt.status = soa_pkg::ST_FULL;
            end else begin
              mem_we              = 1'b1;
              count_nxt           = count_r + CNT_W'(1);
              out_item_nxt.status = soa_pkg::ST_FREED;
            end
          end else if (count_r != '0) begin
            mem_re        = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
            out_valid_nxt = 1'b0;
            state_nxt     = S_POP;
          end else if (left_c >= size_c) begin
            carve_next_nxt           = carve_next_r + ADDR_BITS'(eff_size);
            carve_left_nxt           = LEFT_W'(left_c - size_c);
            out_item_nxt.result_addr = soa_pkg::FIELD_ADDR_W'(carve_next_r);
            out_item_nxt.status      = soa_pkg::ST_ALLOC;
          end else if (in_item.page_ok && (page_a != '0) &&
                       (size_c <= CMP_W'(PAGE_BYTES))) begin
            carve_next_nxt              = page_a + ADDR_BITS'(eff_size);
            carve_left_nxt              = LEFT_W'(CMP_W'(PAGE_BYTES) - size_c);
            out_item_nxt.result_addr    = soa_pkg::FIELD_ADDR_W'(page_a);
            out_item_nxt.status         = soa_pkg::ST_ALLOC;
            out_item_nxt.new_page_taken = 1'b1;
          end else begin
            out_item_nxt.status = soa_pkg::ST_FAIL;
          end
        end
      end
      S_POP: begin
        out_item_nxt.result_addr    = soa_pkg::FIELD_ADDR_W'(rd_data_r);
        out_item_nxt.status         = soa_pkg::ST_ALLOC;
        out_item_nxt.new_page_taken = 1'b0;
        out_valid_nxt               = 1'b1;
        state_nxt                   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      carve_next_r <= '0;
      carve_left_r <= '0;
      obj_size_r   <= soa_pkg::OBJ_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      carve_next_r <= carve_next_nxt;
      carve_left_r <= carve_left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        obj_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
